// File: sv/tfs_pkg.sv
// ----------------------------------------------------------------------------
// Frame sequencer package
// Request codes, chip register numbers and the note period table shared by
// the frame sequencer.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int NOTE_COUNT = 96;

	// Request kinds carried in the operation field.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Sound chip register numbers.
	localparam logic [3:0] REG_TONE_A_LO = 4'd0;
	localparam logic [3:0] REG_TONE_A_HI = 4'd1;
	localparam logic [3:0] REG_TONE_B_LO = 4'd2;
	localparam logic [3:0] REG_TONE_B_HI = 4'd3;
	localparam logic [3:0] REG_TONE_C_LO = 4'd4;
	localparam logic [3:0] REG_TONE_C_HI = 4'd5;
	localparam logic [3:0] REG_NOISE     = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_AMP_A     = 4'd8;
	localparam logic [3:0] REG_AMP_B     = 4'd9;
	localparam logic [3:0] REG_AMP_C     = 4'd10;
	localparam logic [3:0] REG_ENV_FINE  = 4'd11;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	// Module header layout.
	localparam logic [15:0] HDR_SPEED     = 16'd0;
	localparam logic [15:0] HDR_VERSION   = 16'd4;
	localparam logic [15:0] HDR_BASE      = 16'd5;
	localparam logic [15:0] HDR_SAMPLES   = 16'd39;
	localparam logic [15:0] HDR_ORNAMENTS = 16'd69;
	localparam logic [15:0] HDR_PATTERNS  = 16'd101;
	localparam logic [15:0] HDR_POS_COUNT = 16'd293;
	localparam logic [15:0] HDR_LOOP_POS  = 16'd294;
	localparam logic [15:0] HDR_POS_LIST  = 16'd295;

	localparam logic [7:0]  VERSION_NEW   = 8'h10;
	localparam logic [7:0]  PATTERN_END   = 8'd255;
	localparam logic [7:0]  NOTE_MAX      = 8'h5F;
	localparam logic [15:0] PTR_RESET     = 16'd65532;

	localparam logic [11:0] TONE_TABLE [NOTE_COUNT] = '{
		12'h EF8, 12'h E10, 12'h D60, 12'h C80, 12'h BD8, 12'h B28, 12'h A88, 12'h 9F0,
		12'h 960, 12'h 8E0, 12'h 858, 12'h 7E0, 12'h 77C, 12'h 708, 12'h 6B0, 12'h 640,
		12'h 5EC, 12'h 594, 12'h 544, 12'h 4F8, 12'h 4B0, 12'h 470, 12'h 42C, 12'h 3FD,
		12'h 3BE, 12'h 384, 12'h 358, 12'h 320, 12'h 2F6, 12'h 2CA, 12'h 2A2, 12'h 27C,
		12'h 258, 12'h 238, 12'h 216, 12'h 1F8, 12'h 1DF, 12'h 1C2, 12'h 1AC, 12'h 190,
		12'h 17B, 12'h 165, 12'h 151, 12'h 13E, 12'h 12C, 12'h 11C, 12'h 10A, 12'h 0FC,
		12'h 0EF, 12'h 0E1, 12'h 0D6, 12'h 0C8, 12'h 0BD, 12'h 0B2, 12'h 0A8, 12'h 09F,
		12'h 096, 12'h 08E, 12'h 085, 12'h 07E, 12'h 077, 12'h 070, 12'h 06B, 12'h 064,
		12'h 05E, 12'h 059, 12'h 054, 12'h 04F, 12'h 04B, 12'h 047, 12'h 042, 12'h 03F,
		12'h 03B, 12'h 038, 12'h 035, 12'h 032, 12'h 02F, 12'h 02C, 12'h 02A, 12'h 027,
		12'h 025, 12'h 023, 12'h 021, 12'h 01F, 12'h 01D, 12'h 01C, 12'h 01A, 12'h 019,
		12'h 017, 12'h 016, 12'h 015, 12'h 013, 12'h 012, 12'h 011, 12'h 010, 12'h 00F
	};

endpackage

// File: sv/tracker_module_frame_sequencer_top.sv
// ----------------------------------------------------------------------------
// Tracker module frame sequencer
// Replays a three-channel tracker module held in local memory and produces
// the sound chip register writes of each frame.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: a load request writes one module
// byte, a start request reads the header and sets up the channels, and a
// tick request advances the song by one frame. Register writes leave on the
// m_axis channel, one per transfer, with tlast on the amplitude C write that
// closes each tick.
// Start and tick requests read the module memory one byte at a time through
// its single read port, so a tick lasts longer for every module byte read:
// a frame with a new row reads the command run of each channel, and each
// end-of-pattern marker skipped reads the position list and pattern table.
// The block takes a new request only once the previous one is complete.
// A stalled receiver holds the sequencer at its next register write; the
// output register lets the final write wait while the next request enters.
// After reset the channels hold their idle values and the module memory is
// undefined until loaded.
// ----------------------------------------------------------------------------
module tracker_module_frame_sequencer_top
	import tfs_pkg::*;
#(
	parameter int MODULE_BYTES    = 65536,
	parameter int MAX_PATTERN_OPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // operation[1:0], address[17:2], data[25:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // reg_index[3:0], reg_value[11:4]
	output logic        m_axis_tlast   // last
);

	localparam int AW = $clog2(MODULE_BYTES);
	localparam int OW = (MAX_PATTERN_OPS > 2) ? $clog2(MAX_PATTERN_OPS) : 1;
	localparam logic [23:0] MB = 24'(MODULE_BYTES);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_HDR   = 12'b000000000010,
		S_POS   = 12'b000000000100,
		S_TICK  = 12'b000000001000,
		S_SKIP  = 12'b000000010000,
		S_EMPTY = 12'b000000100000,
		S_OP    = 12'b000001000000,
		S_OPX   = 12'b000010000000,
		S_ENV   = 12'b000100000000,
		S_FIN   = 12'b001000000000,
		S_REGS  = 12'b010000000000,
		S_OUT   = 12'b100000000000
	} state_t;

	function automatic logic [AW-1:0] mem_idx(input logic [15:0] a);
		logic [23:0] r;
		r = {8'd0, a};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (MB << k)) r = r - (MB << k);
		end
		return r[AW-1:0];
	endfunction

	logic [7:0] mod_mem [MODULE_BYTES];
	logic [7:0] rd_q;

	state_t state_q;
	logic [3:0] step_q;
	logic rd_ph_q;
	logic [1:0] ch_q;
	logic [OW-1:0] ops_q;
	logic [8:0] k_q;
	logic pos_tick_q;
	logic quit_q;
	logic is_orn_q;
	logic [7:0] op_q;
	logic [7:0] tmp_q;
	logic [7:0] b_q;
	logic [15:0] tab_q;
	logic [15:0] pptr_q;
	logic [8:0] tbase_q;
	logic [11:0] tone_q;
	logic [7:0] mixer_q;
	logic [4:0] noise_q;

	logic [7:0] speed_q, pos_count_q, loop_pos_q, cur_pos_q, countdown_q;
	logic [15:0] base_q;
	logic ver_new_q;

	logic [15:0] pat_q [3];
	logic [6:0] note_q [3];
	logic [7:0] skip_q [3];
	logic [15:0] smp_ptr_q [3];
	logic [7:0] smp_len_q [3];
	logic [7:0] smp_loop_q [3];
	logic [7:0] smp_pos_q [3];
	logic [15:0] orn_ptr_q [3];
	logic [7:0] orn_len_q [3];
	logic [7:0] orn_loop_q [3];
	logic [7:0] orn_pos_q [3];
	logic [7:0] vol_q [3];
	logic on_q [3];
	logic env_q [3];
	logic [11:0] tone_per_q [3];
	logic [4:0] amp_q [3];

	logic out_valid_q;
	logic [3:0] out_idx_q;
	logic [7:0] out_val_q;
	logic out_last_q;

	logic [1:0] in_op;
	logic [15:0] in_addr;
	logic [7:0] in_data;
	logic in_acc, can_emit;
	logic [15:0] raddr, word, smp_addr;
	logic [7:0] note_sum, note_clip, amp_diff, orn_next, smp_next, skip_next;
	logic [7:0] cur_next, mix_on;
	logic [17:0] grp_prod;
	logic [1:0] pos_ch;

	assign in_op   = s_axis_tdata[1:0];
	assign in_addr = s_axis_tdata[17:2];
	assign in_data = s_axis_tdata[25:18];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign can_emit = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_val_q, out_idx_q};
	assign m_axis_tlast  = out_last_q;

	assign word      = {rd_q, tmp_q};
	assign smp_addr  = smp_ptr_q[ch_q] + {8'd0, smp_pos_q[ch_q]};
	assign note_sum  = {1'b0, note_q[ch_q]} + rd_q;
	assign note_clip = (note_sum > NOTE_MAX) ? NOTE_MAX : note_sum;
	assign amp_diff  = rd_q - vol_q[ch_q];
	assign orn_next  = orn_pos_q[ch_q] + 8'd1;
	assign smp_next  = smp_pos_q[ch_q] + 8'd4;
	assign skip_next = skip_q[ch_q] - 8'd1;
	assign cur_next  = cur_pos_q + 8'd1;
	assign mix_on    = mixer_q | (b_q[6] ? 8'h40 : 8'h00) | (b_q[5] ? 8'h08 : 8'h00);
	// Division by six of a byte: (x * 171) >> 10 is exact over the byte range.
	assign grp_prod  = {10'd0, rd_q} * 18'd171;
	assign pos_ch    = 2'(step_q[3:1] - 3'd1);

	always_comb begin
		case (state_q)
			S_HDR: begin
				case (step_q)
					4'd0:    raddr = HDR_SPEED;
					4'd1:    raddr = HDR_VERSION;
					4'd2:    raddr = HDR_BASE;
					4'd3:    raddr = HDR_BASE + 16'd1;
					4'd4:    raddr = HDR_POS_COUNT;
					default: raddr = HDR_LOOP_POS;
				endcase
			end
			S_POS:   raddr = (step_q == 4'd0) ? HDR_POS_LIST + {8'd0, cur_pos_q}
				: {7'd0, tbase_q} + {12'd0, step_q} - 16'd1;
			S_EMPTY: raddr = pat_q[0];
			S_OP:    raddr = pat_q[ch_q];
			S_ENV:   raddr = pat_q[ch_q];
			S_OPX: begin
				case (step_q)
					4'd0:    raddr = tab_q;
					4'd1:    raddr = tab_q + 16'd1;
					4'd2:    raddr = pptr_q;
					default: raddr = pptr_q + 16'd1;
				endcase
			end
			S_REGS: begin
				case (step_q)
					4'd0:    raddr = orn_ptr_q[ch_q] + {8'd0, orn_pos_q[ch_q]};
					4'd1:    raddr = smp_addr + 16'd2;
					4'd2:    raddr = smp_addr + 16'd3;
					4'd3:    raddr = smp_addr + 16'd1;
					default: raddr = smp_addr;
				endcase
			end
			default: raddr = 16'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_LOAD) mod_mem[mem_idx(in_addr)] <= in_data;
		rd_q <= mod_mem[mem_idx(raddr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			rd_ph_q <= 1'b0;
			ch_q <= '0;
			ops_q <= '0;
			k_q <= '0;
			pos_tick_q <= 1'b0;
			quit_q <= 1'b0;
			is_orn_q <= 1'b0;
			mixer_q <= '0;
			noise_q <= '0;
			speed_q <= '0;
			base_q <= '0;
			ver_new_q <= 1'b0;
			pos_count_q <= '0;
			loop_pos_q <= '0;
			cur_pos_q <= '0;
			countdown_q <= 8'd1;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				pat_q[c] <= '0;
				note_q[c] <= '0;
				skip_q[c] <= '0;
				smp_ptr_q[c] <= PTR_RESET;
				smp_len_q[c] <= 8'd4;
				smp_loop_q[c] <= '0;
				smp_pos_q[c] <= '0;
				orn_ptr_q[c] <= PTR_RESET;
				orn_len_q[c] <= 8'd1;
				orn_loop_q[c] <= '0;
				orn_pos_q[c] <= '0;
				vol_q[c] <= '0;
				on_q[c] <= 1'b1;
				env_q[c] <= 1'b0;
				tone_per_q[c] <= '0;
				amp_q[c] <= '0;
			end
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					rd_ph_q <= 1'b0;
					if (in_acc && in_op == OP_START) state_q <= S_HDR;
					if (in_acc && in_op == OP_TICK) state_q <= S_TICK;
				end
				S_HDR: begin
					rd_ph_q <= !rd_ph_q;
					if (rd_ph_q) begin
						step_q <= step_q + 4'd1;
						case (step_q)
							4'd0: speed_q <= rd_q;
							4'd1: ver_new_q <= (rd_q == VERSION_NEW);
							4'd2: base_q[7:0] <= rd_q;
							4'd3: base_q[15:8] <= rd_q;
							4'd4: pos_count_q <= rd_q;
							default: begin
								loop_pos_q <= rd_q;
								cur_pos_q <= '0;
								countdown_q <= 8'd1;
								step_q <= '0;
								pos_tick_q <= 1'b0;
								state_q <= S_POS;
								for (int c = 0; c < 3; c++) begin
									note_q[c] <= '0;
									skip_q[c] <= '0;
									smp_ptr_q[c] <= PTR_RESET;
									smp_len_q[c] <= 8'd4;
									smp_loop_q[c] <= '0;
									smp_pos_q[c] <= '0;
									orn_ptr_q[c] <= PTR_RESET;
									orn_len_q[c] <= 8'd1;
									orn_loop_q[c] <= '0;
									orn_pos_q[c] <= '0;
									vol_q[c] <= '0;
									on_q[c] <= 1'b1;
									env_q[c] <= 1'b0;
									tone_per_q[c] <= '0;
									amp_q[c] <= '0;
								end
							end
						endcase
					end
				end
				S_POS: begin
					rd_ph_q <= !rd_ph_q;
					if (rd_ph_q) begin
						step_q <= step_q + 4'd1;
						if (step_q == 4'd0) begin
							tbase_q <= 9'(HDR_PATTERNS) + 9'(grp_prod[17:10]) * 9'd6;
						end else if (!step_q[0]) begin
							pat_q[pos_ch] <= word - base_q;
						end else begin
							tmp_q <= rd_q;
						end
						if (step_q == 4'd6) begin
							step_q <= '0;
							state_q <= pos_tick_q ? S_EMPTY : S_IDLE;
						end
					end
				end
				S_TICK: begin
					mixer_q <= '0;
					noise_q <= '0;
					ch_q <= '0;
					step_q <= '0;
					rd_ph_q <= 1'b0;
					if (countdown_q == 8'd1) begin
						countdown_q <= speed_q;
						state_q <= S_SKIP;
					end else begin
						countdown_q <= countdown_q - 8'd1;
						state_q <= S_REGS;
					end
				end
				S_SKIP: begin
					skip_q[ch_q] <= skip_next;
					ops_q <= '0;
					k_q <= '0;
					step_q <= '0;
					rd_ph_q <= 1'b0;
					if (skip_next[7]) begin
						skip_q[ch_q] <= '0;
						state_q <= (ch_q == 2'd0) ? S_EMPTY : S_OP;
					end else if (ch_q == 2'd2) begin
						ch_q <= '0;
						state_q <= S_REGS;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				S_EMPTY: begin
					rd_ph_q <= !rd_ph_q;
					if (rd_ph_q) begin
						step_q <= '0;
						// Skip over patterns that end at once, at most 256 times.
						if (rd_q == PATTERN_END && !k_q[8]) begin
							k_q <= k_q + 9'd1;
							cur_pos_q <= (cur_next == pos_count_q) ? loop_pos_q : cur_next;
							pos_tick_q <= 1'b1;
							state_q <= S_POS;
						end else begin
							state_q <= S_OP;
						end
					end
				end
				S_OP: begin
					rd_ph_q <= !rd_ph_q;
					if (rd_ph_q) begin
						op_q <= rd_q;
						quit_q <= 1'b0;
						step_q <= '0;
						state_q <= S_FIN;
						if (rd_q <= NOTE_MAX) begin
							note_q[ch_q] <= rd_q[6:0];
							smp_pos_q[ch_q] <= '0;
							orn_pos_q[ch_q] <= '0;
							on_q[ch_q] <= 1'b1;
							quit_q <= 1'b1;
						end else if (rd_q inside {[8'h60:8'h6F]}) begin
							tab_q <= HDR_SAMPLES + {11'd0, rd_q[3:0], 1'b0};
							is_orn_q <= 1'b0;
							state_q <= S_OPX;
						end else if (rd_q inside {[8'h70:8'h7F]}) begin
							tab_q <= HDR_ORNAMENTS + {11'd0, rd_q[3:0], 1'b0};
							is_orn_q <= 1'b1;
							state_q <= S_OPX;
						end else if (rd_q inside {[8'h80:8'hBF]}) begin
							skip_q[ch_q] <= rd_q - 8'h80;
						end else if (rd_q inside {[8'hC0:8'hCF]}) begin
							state_q <= S_ENV;
						end else if (rd_q inside {[8'hD0:8'hDF]}) begin
							quit_q <= 1'b1;
						end else if (rd_q == 8'hE0) begin
							on_q[ch_q] <= 1'b0;
							quit_q <= !ver_new_q;
						end else begin
							vol_q[ch_q] <= 8'd15 - (rd_q - 8'hE0);
						end
					end
				end
				S_OPX: begin
					rd_ph_q <= !rd_ph_q;
					if (rd_ph_q) begin
						step_q <= step_q + 4'd1;
						case (step_q)
							4'd0: tmp_q <= rd_q;
							4'd1: pptr_q <= word - base_q;
							4'd2: begin
								if (is_orn_q) orn_loop_q[ch_q] <= rd_q;
								else smp_loop_q[ch_q] <= rd_q;
							end
							default: begin
								if (is_orn_q) begin
									orn_len_q[ch_q] <= rd_q;
									orn_ptr_q[ch_q] <= pptr_q + 16'd2;
									orn_pos_q[ch_q] <= '0;
									if (!ver_new_q) env_q[ch_q] <= 1'b0;
								end else begin
									smp_len_q[ch_q] <= rd_q;
									smp_ptr_q[ch_q] <= pptr_q + 16'd2;
								end
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ENV: begin
					case (step_q)
						4'd0: begin
							if (can_emit) begin
								out_valid_q <= 1'b1;
								out_idx_q <= REG_ENV_SHAPE;
								out_val_q <= {4'd0, op_q[3:0]};
								out_last_q <= 1'b0;
								pat_q[ch_q] <= pat_q[ch_q] + 16'd1;
								step_q <= 4'd1;
								rd_ph_q <= 1'b0;
							end
						end
						4'd1: begin
							rd_ph_q <= !rd_ph_q;
							if (rd_ph_q) begin
								tmp_q <= rd_q;
								step_q <= 4'd2;
							end
						end
						default: begin
							if (can_emit) begin
								out_valid_q <= 1'b1;
								out_idx_q <= REG_ENV_FINE;
								out_val_q <= tmp_q;
								out_last_q <= 1'b0;
								env_q[ch_q] <= 1'b1;
								state_q <= S_FIN;
							end
						end
					endcase
				end
				S_FIN: begin
					pat_q[ch_q] <= pat_q[ch_q] + 16'd1;
					step_q <= '0;
					rd_ph_q <= 1'b0;
					if (quit_q || ops_q == OW'(MAX_PATTERN_OPS - 1)) begin
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							state_q <= S_REGS;
						end else begin
							ch_q <= ch_q + 2'd1;
							state_q <= S_SKIP;
						end
					end else begin
						ops_q <= ops_q + OW'(1);
						state_q <= S_OP;
					end
				end
				S_REGS: begin
					if (!on_q[ch_q]) begin
						amp_q[ch_q] <= '0;
						mixer_q <= (mixer_q | 8'h48) >> 1;
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd2) begin
							ch_q <= '0;
							state_q <= S_OUT;
						end
					end else begin
						rd_ph_q <= !rd_ph_q;
						if (rd_ph_q) begin
							step_q <= step_q + 4'd1;
							case (step_q)
								4'd0: begin
									tone_q <= TONE_TABLE[note_clip[6:0]];
									orn_pos_q[ch_q] <= (orn_next == orn_len_q[ch_q])
										? orn_loop_q[ch_q] : orn_next;
								end
								4'd1: tmp_q <= rd_q;
								4'd2: tone_per_q[ch_q] <= tone_q + word[11:0];
								4'd3: begin
									b_q <= rd_q;
									noise_q <= noise_q | rd_q[4:0];
								end
								default: begin
									amp_q[ch_q] <= {b_q[7] & env_q[ch_q],
										amp_diff[7] ? 4'd0 : amp_diff[3:0]};
									mixer_q <= mix_on >> 1;
									smp_pos_q[ch_q] <= (smp_next == smp_len_q[ch_q])
										? smp_loop_q[ch_q] : smp_next;
									step_q <= '0;
									ch_q <= ch_q + 2'd1;
									if (ch_q == 2'd2) begin
										ch_q <= '0;
										state_q <= S_OUT;
									end
								end
							endcase
						end
					end
				end
				S_OUT: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_last_q <= 1'b0;
						step_q <= step_q + 4'd1;
						case (step_q)
							4'd0: begin
								out_idx_q <= REG_MIXER;
								out_val_q <= mixer_q;
							end
							4'd1: begin
								out_idx_q <= REG_NOISE;
								out_val_q <= {3'd0, noise_q};
							end
							4'd2: begin
								out_idx_q <= REG_TONE_A_LO;
								out_val_q <= tone_per_q[0][7:0];
							end
							4'd3: begin
								out_idx_q <= REG_TONE_A_HI;
								out_val_q <= {4'd0, tone_per_q[0][11:8]};
							end
							4'd4: begin
								out_idx_q <= REG_TONE_B_LO;
								out_val_q <= tone_per_q[1][7:0];
							end
							4'd5: begin
								out_idx_q <= REG_TONE_B_HI;
								out_val_q <= {4'd0, tone_per_q[1][11:8]};
							end
							4'd6: begin
								out_idx_q <= REG_TONE_C_LO;
								out_val_q <= tone_per_q[2][7:0];
							end
							4'd7: begin
								out_idx_q <= REG_TONE_C_HI;
								out_val_q <= {4'd0, tone_per_q[2][11:8]};
							end
							4'd8: begin
								out_idx_q <= REG_AMP_A;
								out_val_q <= {3'd0, amp_q[0]};
							end
							4'd9: begin
								out_idx_q <= REG_AMP_B;
								out_val_q <= {3'd0, amp_q[1]};
							end
							default: begin
								out_idx_q <= REG_AMP_C;
								out_val_q <= {3'd0, amp_q[2]};
								out_last_q <= 1'b1;
								step_q <= '0;
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The channel counter only ever names one of the three channels.
	assert property (@(posedge clk) disable iff (!arst_n) ch_q != 2'd3)
		else $error("channel index out of range");

	// The closing write of a tick is always amplitude C.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_idx_q == REG_AMP_C)
		else $error("tlast on a write other than amplitude C");

	// A tick request keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_op == OP_TICK |=> !s_axis_tready)
		else $error("ready after tick request");

	// A new result is only loaded when the previous one is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(out_idx_q) && $stable(out_val_q))
		else $error("pending register write overwritten");

endmodule
